// ----- src/fdcp_pkg.sv -----
// Package for the framed drive command parser: character codes, widths,
// register map and the result record passed from the frame parser to the top level.
// Depends on nothing; every other file of the block refers to it by scoped names.
`default_nettype none

package fdcp_pkg;

    // Frame buffer length of the original firmware; two places are reserved,
    // so at most BUFFER_LEN-2 nonzero frame bytes are parsed.
    localparam int BUFFER_LEN = 50;
    localparam int KEPT_MAX   = BUFFER_LEN - 2;
    localparam int KEPT_W     = $clog2(KEPT_MAX + 1);

    localparam int BYTE_W  = 8;
    localparam int DIR_W   = 2;
    localparam int SPEED_W = 8;
    localparam int ACC_W   = 9;

    // ASCII characters that the parser recognises.
    localparam logic [BYTE_W-1:0] CH_NUL  = 8'h00;
    localparam logic [BYTE_W-1:0] CH_DASH = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_OPEN = 8'h28;
    localparam logic [BYTE_W-1:0] CH_W    = 8'h77;
    localparam logic [BYTE_W-1:0] CH_S    = 8'h73;
    localparam logic [BYTE_W-1:0] CH_A    = 8'h61;
    localparam logic [BYTE_W-1:0] CH_D    = 8'h64;
    localparam logic [BYTE_W-1:0] CH_ZERO = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE = 8'h39;

    // Direction codes carried in the result.
    localparam logic [DIR_W-1:0] DIR_FORWARD  = 2'd0;
    localparam logic [DIR_W-1:0] DIR_BACKWARD = 2'd1;
    localparam logic [DIR_W-1:0] DIR_LEFT     = 2'd2;
    localparam logic [DIR_W-1:0] DIR_RIGHT    = 2'd3;

    // Speed accumulator saturation and output clamp.
    localparam logic [ACC_W-1:0]   ACC_SAT   = 9'd256;
    localparam logic [SPEED_W-1:0] SPEED_MAX = 8'd255;

    // Configuration port: one register, dead_zone, at byte address 0.
    localparam int                PADDR_W        = 2;
    localparam int                PDATA_W        = 32;
    localparam logic [PADDR_W-1:0] ADDR_DEAD_ZONE = 2'd0;
    localparam logic [SPEED_W-1:0] DEAD_ZONE_RST  = 8'd30;

    // What the frame parser reports for the byte currently presented to it.
    typedef struct packed {
        logic                produce;
        logic                frame_ok;
        logic [DIR_W-1:0]    direction_code;
        logic [SPEED_W-1:0]  speed;
    } t_cmd_result;

endpackage

`default_nettype wire

// ----- src/fdcp_if.sv -----
// Valid/ready channel interfaces of the framed drive command parser:
// one for received bytes and one for parsed commands. Uses fdcp_pkg.
`default_nettype none

interface fdcp_rx_if;
    logic                           valid;
    logic                           ready;
    logic [fdcp_pkg::BYTE_W-1:0]    rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface fdcp_cmd_if;
    logic                           valid;
    logic                           ready;
    logic                           frame_ok;
    logic [fdcp_pkg::DIR_W-1:0]     direction_code;
    logic [fdcp_pkg::SPEED_W-1:0]   speed;

    modport source (output valid, output frame_ok, output direction_code, output speed,
                    input ready);
    modport sink   (input valid, input frame_ok, input direction_code, input speed,
                    output ready);
endinterface

`default_nettype wire

// ----- src/fdcp_frame_parser.sv -----
// Frame state of the command parser: hunt/collect flag, parse phase, kept
// byte count, direction and speed accumulator. Uses fdcp_pkg.
`default_nettype none

module fdcp_frame_parser (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_step,
    input  wire logic [fdcp_pkg::BYTE_W-1:0]   i_byte,
    input  wire logic [fdcp_pkg::SPEED_W-1:0]  i_dead_zone,
    output fdcp_pkg::t_cmd_result              o_result
);

    localparam logic [2:0] PH_SEEK_OPEN   = 3'd0;
    localparam logic [2:0] PH_DIRECTION   = 3'd1;
    localparam logic [2:0] PH_SEEK_SECOND = 3'd2;
    localparam logic [2:0] PH_SKIP        = 3'd3;
    localparam logic [2:0] PH_DIGITS      = 3'd4;
    localparam logic [2:0] PH_DONE        = 3'd5;

    logic                              r_in_frame, n_in_frame;
    logic [2:0]                        r_phase, n_phase;
    logic [fdcp_pkg::KEPT_W-1:0]       r_kept, n_kept;
    logic [fdcp_pkg::DIR_W-1:0]        r_dir, n_dir;
    logic                              r_dir_valid, n_dir_valid;
    logic [fdcp_pkg::ACC_W-1:0]        r_acc, n_acc;

    logic                              w_is_dash;
    logic                              w_is_digit;
    logic [fdcp_pkg::BYTE_W-1:0]       w_diff;
    logic [11:0]                       w_acc_next;
    logic [fdcp_pkg::ACC_W-1:0]        w_acc_sat;
    logic                              w_ok;

    assign w_is_dash  = (i_byte == fdcp_pkg::CH_DASH);
    assign w_is_digit = (i_byte >= fdcp_pkg::CH_ZERO) && (i_byte <= fdcp_pkg::CH_NINE);
    assign w_diff     = i_byte - fdcp_pkg::CH_ZERO;

    // acc * 10 + digit as (acc << 3) + (acc << 1) + digit.
    assign w_acc_next = {r_acc, 3'b000} + {2'b00, r_acc, 1'b0} + {8'b0, w_diff[3:0]};
    assign w_acc_sat  = (w_acc_next > 12'(fdcp_pkg::ACC_SAT)) ? fdcp_pkg::ACC_SAT
                                                              : w_acc_next[fdcp_pkg::ACC_W-1:0];

    always_comb begin
        n_in_frame  = r_in_frame;
        n_phase     = r_phase;
        n_kept      = r_kept;
        n_dir       = r_dir;
        n_dir_valid = r_dir_valid;
        n_acc       = r_acc;
        if (i_step) begin
            if (!r_in_frame || w_is_dash) begin
                // A dash either opens a frame from hunt or closes the open one.
                if (w_is_dash) begin
                    n_in_frame = !r_in_frame;
                end
                n_phase     = PH_SEEK_OPEN;
                n_kept      = '0;
                n_dir       = fdcp_pkg::DIR_FORWARD;
                n_dir_valid = 1'b0;
                n_acc       = '0;
                if (!r_in_frame && !w_is_dash) begin
                    n_phase     = r_phase;
                    n_kept      = r_kept;
                    n_dir       = r_dir;
                    n_dir_valid = r_dir_valid;
                    n_acc       = r_acc;
                end
            end else if ((i_byte != fdcp_pkg::CH_NUL)
                         && (r_kept < fdcp_pkg::KEPT_W'(fdcp_pkg::KEPT_MAX))) begin
                n_kept = r_kept + fdcp_pkg::KEPT_W'(1);
                unique case (r_phase)
                    PH_SEEK_OPEN: begin
                        if (i_byte == fdcp_pkg::CH_OPEN) begin
                            n_phase = PH_DIRECTION;
                        end
                    end
                    PH_DIRECTION: begin
                        n_dir_valid = 1'b1;
                        case (i_byte)
                            fdcp_pkg::CH_W: n_dir = fdcp_pkg::DIR_FORWARD;
                            fdcp_pkg::CH_S: n_dir = fdcp_pkg::DIR_BACKWARD;
                            fdcp_pkg::CH_A: n_dir = fdcp_pkg::DIR_LEFT;
                            fdcp_pkg::CH_D: n_dir = fdcp_pkg::DIR_RIGHT;
                            default: begin
                                n_dir       = fdcp_pkg::DIR_FORWARD;
                                n_dir_valid = 1'b0;
                            end
                        endcase
                        // An open bracket in the direction slot also opens the speed field.
                        n_phase = (i_byte == fdcp_pkg::CH_OPEN) ? PH_SKIP : PH_SEEK_SECOND;
                    end
                    PH_SEEK_SECOND: begin
                        if (i_byte == fdcp_pkg::CH_OPEN) begin
                            n_phase = PH_SKIP;
                        end
                    end
                    PH_SKIP: begin
                        if (w_is_digit) begin
                            n_acc   = {5'b0, w_diff[3:0]};
                            n_phase = PH_DIGITS;
                        end
                    end
                    PH_DIGITS: begin
                        if (w_is_digit) begin
                            n_acc = w_acc_sat;
                        end else begin
                            n_phase = PH_DONE;
                        end
                    end
                    default: begin
                        n_phase = r_phase;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame  <= 1'b0;
            r_phase     <= PH_SEEK_OPEN;
            r_kept      <= '0;
            r_dir       <= fdcp_pkg::DIR_FORWARD;
            r_dir_valid <= 1'b0;
            r_acc       <= '0;
        end else begin
            r_in_frame  <= n_in_frame;
            r_phase     <= n_phase;
            r_kept      <= n_kept;
            r_dir       <= n_dir;
            r_dir_valid <= n_dir_valid;
            r_acc       <= n_acc;
        end
    end

    // Result for the byte on i_byte, meaningful when it closes a frame.
    assign w_ok = r_dir_valid && (r_phase >= PH_SKIP);

    always_comb begin
        o_result.produce        = r_in_frame && w_is_dash;
        o_result.frame_ok       = w_ok;
        o_result.direction_code = w_ok ? r_dir : fdcp_pkg::DIR_FORWARD;
        if (!w_ok || (r_acc < {1'b0, i_dead_zone})) begin
            o_result.speed = '0;
        end else if (r_acc[fdcp_pkg::ACC_W-1]) begin
            o_result.speed = fdcp_pkg::SPEED_MAX;
        end else begin
            o_result.speed = r_acc[fdcp_pkg::SPEED_W-1:0];
        end
    end

endmodule

`default_nettype wire

// ----- src/framed_drive_command_parser.sv -----
// Top level of the framed drive command parser: byte input register, frame
// parser, command output register and the APB dead-zone register. Uses fdcp_pkg,
// fdcp_rx_if, fdcp_cmd_if and fdcp_frame_parser.
`default_nettype none

// Framed drive command parser. Received ASCII bytes enter on i_rx, one per
// transaction, and drive commands leave on o_cmd. Frames have the form
// -(<dir>)(<speed>)-: outside a frame every byte but '-' is dropped; inside,
// bytes are parsed until the next '-', which yields exactly one command
// transaction and returns the block to hunting (that closing '-' does not
// open a new frame). A command is good (frame_ok = 1) when the frame holds an
// open bracket followed by w, s, a or d and then a later open bracket; the
// speed is the first run of decimal digits after that, saturated to 255, and
// reported as zero when below the dead_zone register. A failed frame gives
// frame_ok = 0 with direction and speed zero. Zero bytes inside a frame are
// ignored, and only the first BUFFER_LEN-2 nonzero frame bytes are parsed.
// Rate: one byte per clock cycle while the input does not stall. A byte is
// taken into an input register and, when it moves on, its effect on the frame
// state and any command are computed in a single pass and written to the
// output register, so a command is offered on o_cmd from the output register
// once its closing '-' has left the input register. The input side keeps
// accepting while a command waits in the output register; it stalls only
// when a second command is ready behind an unread one.
// dead_zone is written through APB at address 0 (reset value 30) and should
// be changed only while no byte is in flight.

module framed_drive_command_parser (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    fdcp_rx_if.sink                              i_rx,
    fdcp_cmd_if.source                           o_cmd,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [fdcp_pkg::PADDR_W-1:0]    paddr,
    input  wire logic [fdcp_pkg::PDATA_W-1:0]    pwdata,
    output logic      [fdcp_pkg::PDATA_W-1:0]    prdata,
    output logic                                 pready
);

    // Input register.
    logic                              r_in_valid;
    logic [fdcp_pkg::BYTE_W-1:0]       r_in_byte;

    // Output register.
    logic                              r_out_valid;
    logic                              r_out_ok;
    logic [fdcp_pkg::DIR_W-1:0]        r_out_dir;
    logic [fdcp_pkg::SPEED_W-1:0]      r_out_speed;

    // Configuration.
    logic [fdcp_pkg::SPEED_W-1:0]      r_dead_zone;

    fdcp_pkg::t_cmd_result             w_res;
    logic                              w_advance;
    logic                              w_take_in;
    logic                              w_cfg_write;

    // The held byte moves on unless it makes a command that has nowhere to go.
    assign w_advance = r_in_valid && (!w_res.produce || !r_out_valid || o_cmd.ready);
    assign i_rx.ready = !r_in_valid || w_advance;
    assign w_take_in  = i_rx.valid && i_rx.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_take_in) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take_in) begin
            r_in_byte <= i_rx.rx_byte;
        end
    end

    fdcp_frame_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_advance),
        .i_byte      (r_in_byte),
        .i_dead_zone (r_dead_zone),
        .o_result    (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && w_res.produce) begin
            r_out_valid <= 1'b1;
        end else if (o_cmd.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_res.produce) begin
            r_out_ok    <= w_res.frame_ok;
            r_out_dir   <= w_res.direction_code;
            r_out_speed <= w_res.speed;
        end
    end

    assign o_cmd.valid          = r_out_valid;
    assign o_cmd.frame_ok       = r_out_ok;
    assign o_cmd.direction_code = r_out_dir;
    assign o_cmd.speed          = r_out_speed;

    // APB register: the write lands in the access phase; the port never waits.
    assign w_cfg_write = psel && penable && pwrite && (paddr == fdcp_pkg::ADDR_DEAD_ZONE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dead_zone <= fdcp_pkg::DEAD_ZONE_RST;
        end else if (w_cfg_write) begin
            r_dead_zone <= pwdata[fdcp_pkg::SPEED_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == fdcp_pkg::ADDR_DEAD_ZONE)
                    ? {{(fdcp_pkg::PDATA_W - fdcp_pkg::SPEED_W){1'b0}}, r_dead_zone}
                    : '0;

endmodule

`default_nettype wire

// ----- src/fdcp_checker.sv -----
// Port-level checks for the framed drive command parser, attached to the top
// level by the bind at the end of this file. Uses fdcp_pkg.
`default_nettype none

module fdcp_checker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_rx_valid,
    input  wire logic                          i_rx_ready,
    input  wire logic [fdcp_pkg::BYTE_W-1:0]   i_rx_byte,
    input  wire logic                          i_cmd_valid,
    input  wire logic                          i_cmd_ready,
    input  wire logic                          i_cmd_ok,
    input  wire logic [fdcp_pkg::DIR_W-1:0]    i_cmd_dir,
    input  wire logic [fdcp_pkg::SPEED_W-1:0]  i_cmd_speed
);

    // Reset empties the output register.
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !i_cmd_valid)
        else $error("command valid after reset");

    // A command that is not taken stays offered.
    a_cmd_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_valid && !i_cmd_ready |=> i_cmd_valid)
        else $error("command withdrawn before it was taken");

    // A failed frame carries zero direction and speed.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_valid && !i_cmd_ok |-> (i_cmd_dir == '0) && (i_cmd_speed == '0))
        else $error("failed frame with nonzero fields");

    // A command that waits keeps its fields unchanged until it is taken.
    a_cmd_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_valid && !i_cmd_ready |=> $stable({i_cmd_ok, i_cmd_dir, i_cmd_speed}))
        else $error("command fields changed while waiting");

endmodule

bind framed_drive_command_parser fdcp_checker u_fdcp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_rx_valid  (i_rx.valid),
    .i_rx_ready  (i_rx.ready),
    .i_rx_byte   (i_rx.rx_byte),
    .i_cmd_valid (o_cmd.valid),
    .i_cmd_ready (o_cmd.ready),
    .i_cmd_ok    (o_cmd.frame_ok),
    .i_cmd_dir   (o_cmd.direction_code),
    .i_cmd_speed (o_cmd.speed)
);

`default_nettype wire
